// File: sv/ocd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_pkg: shared types and constants for the orientation classifier
// Side codes, register indexes, reset values and the front-to-back item type.
// ----------------------------------------------------------------------------
package ocd_pkg;

	typedef enum logic [2:0] {
		SIDE_UNKNOWN = 3'd0,
		SIDE_FLAT    = 3'd1,
		SIDE_SHORT_A = 3'd2,
		SIDE_SHORT_B = 3'd3,
		SIDE_LONG    = 3'd4
	} side_t;

	localparam logic [2:0] REG_SIDE_AXIS_THR = 3'd0;
	localparam logic [2:0] REG_SIDE_CROSS    = 3'd1;
	localparam logic [2:0] REG_FLAT_AXIS_THR = 3'd2;
	localparam logic [2:0] REG_FLAT_CROSS    = 3'd3;
	localparam logic [2:0] REG_SETTLE_MS     = 3'd4;
	localparam logic [2:0] REG_FACE_DOWN     = 3'd5;

	localparam logic [14:0] RST_SIDE_AXIS_THR = 15'd3195;
	localparam logic [14:0] RST_SIDE_CROSS    = 15'd1720;
	localparam logic [14:0] RST_FLAT_AXIS_THR = 15'd3441;
	localparam logic [14:0] RST_FLAT_CROSS    = 15'd1229;
	localparam logic [15:0] RST_SETTLE_MS     = 16'd700;
	localparam logic [1:0]  RST_FACE_DOWN     = 2'b11;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [14:0] side_axis_thr;
		logic [14:0] side_cross;
		logic [14:0] flat_axis_thr;
		logic [14:0] flat_cross;
		logic [15:0] settle_ms;
		logic [1:0]  face_down;
	} cfg_t;

	typedef struct packed {
		logic        unavail;
		side_t       raw;
		logic        down;
		logic [31:0] ts;
	} item_t;

endpackage

// File: sv/ocd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_front: sample classifier
// Takes input items, sorts each sample into a side class and flags screen
// down, then hands the item to the queue.
// ----------------------------------------------------------------------------
module ocd_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        timestamp_ms,
	input  ocd_pkg::cfg_t      cfg,
	input  logic               q_full,
	output logic               q_push,
	output ocd_pkg::item_t     q_item
);
	import ocd_pkg::*;

	logic [16:0] xe, ye, ze;
	logic [16:0] ax, ay, az;
	logic [16:0] side_thr, side_cross, flat_thr, flat_cross, neg_side_thr;
	logic [17:0] z18, oz;
	logic        flat_hit, a_hit, b_hit, long_hit, down;
	side_t       raw;

	always_comb begin
		xe = {accel_x[15], accel_x};
		ye = {accel_y[15], accel_y};
		ze = {accel_z[15], accel_z};
		// full-scale negative gives 32768, hence the extra bit
		ax = accel_x[15] ? (~xe + 17'd1) : xe;
		ay = accel_y[15] ? (~ye + 17'd1) : ye;
		az = accel_z[15] ? (~ze + 17'd1) : ze;

		side_thr     = {2'b00, cfg.side_axis_thr};
		side_cross   = {2'b00, cfg.side_cross};
		flat_thr     = {2'b00, cfg.flat_axis_thr};
		flat_cross   = {2'b00, cfg.flat_cross};
		neg_side_thr = ~side_thr + 17'd1;

		flat_hit = (az >= flat_thr) && (ax <= flat_cross) && (ay <= flat_cross);
		a_hit    = ($signed(xe) >= $signed(side_thr))
		           && (ay <= side_cross) && (az <= side_cross);
		b_hit    = ($signed(xe) <= $signed(neg_side_thr))
		           && (ay <= side_cross) && (az <= side_cross);
		long_hit = (ay >= side_thr) && (ax <= side_cross) && (az <= side_cross);

		if (flat_hit) begin
			raw = SIDE_FLAT;
		end else if (a_hit) begin
			raw = SIDE_SHORT_A;
		end else if (b_hit) begin
			raw = SIDE_SHORT_B;
		end else if (long_hit) begin
			raw = SIDE_LONG;
		end else begin
			raw = SIDE_UNKNOWN;
		end

		// only the sign bit of the face-down code picks the direction
		z18 = {{2{accel_z[15]}}, accel_z};
		oz  = cfg.face_down[1] ? (~z18 + 18'd1) : z18;
		down = (cfg.face_down != 2'b00)
		       && ($signed(oz) >= $signed({3'b000, cfg.flat_axis_thr}))
		       && (ax <= flat_cross) && (ay <= flat_cross);
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.unavail = action;
		q_item.raw     = action ? SIDE_UNKNOWN : raw;
		q_item.down    = action ? 1'b0 : down;
		q_item.ts      = timestamp_ms;
	end

endmodule

// File: sv/ocd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_queue: classified item queue
// Short first-in first-out store between the classifier and the stabiliser.
// ----------------------------------------------------------------------------
module ocd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ocd_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output ocd_pkg::item_t head
);
	import ocd_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ocd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_back: stabiliser and result register
// Tracks the candidate class and its start time, promotes it to stable once
// it has persisted long enough, and holds each result until it is taken.
// ----------------------------------------------------------------------------
module ocd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    settle_ms,
	input  logic           q_empty,
	input  ocd_pkg::item_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     raw_side,
	output logic [2:0]     stable_side,
	output logic           screen_down
);
	import ocd_pkg::*;

	side_t       cand_q, stable_q;
	logic [31:0] cand_start_q;
	logic        out_valid_q;
	side_t       raw_q, stable_out_q;
	logic        down_q;
	logic [31:0] elapsed;
	side_t       stable_nxt;

	assign q_pop   = !q_empty && (!out_valid_q || out_ready);
	// wrapping subtraction copes with timestamp roll-over
	assign elapsed = q_head.ts - cand_start_q;

	always_comb begin
		stable_nxt = stable_q;
		if (q_head.unavail) begin
			stable_nxt = SIDE_UNKNOWN;
		end else if (q_head.raw == cand_q && elapsed >= {16'h0000, settle_ms}) begin
			stable_nxt = cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q       <= SIDE_UNKNOWN;
			stable_q     <= SIDE_UNKNOWN;
			cand_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				stable_q <= stable_nxt;
				if (!q_head.unavail && q_head.raw != cand_q) begin
					cand_q       <= q_head.raw;
					cand_start_q <= q_head.ts;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			raw_q        <= q_head.raw;
			stable_out_q <= stable_nxt;
			down_q       <= q_head.down;
		end
	end

	assign out_valid   = out_valid_q;
	assign raw_side    = raw_q;
	assign stable_side = stable_out_q;
	assign screen_down = down_q;

endmodule

// File: sv/orientation_classify_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orientation_classify_debounce: accelerometer orientation with debounce
// Input samples arrive on in_valid/in_ready with action, accel_x/y/z (Q3.12)
// and timestamp_ms. Each item gives one result on out_valid/out_ready:
// raw_side, stable_side and screen_down.
// A classifier front end writes classified items into a two-entry queue; a
// stabiliser back end drains it into a result register.
// An accepted item passes through the queue into the registered result.
// Throughput: one item per cycle while out_ready is high, set by the
// combinational classifier and the one-item-per-cycle stabiliser update.
// When out_ready is low the result register holds; the queue absorbs two
// more items, then in_ready drops until the result is taken.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while no item is in flight. Unknown indexes are ignored.
// Reset empties the queue and result register, sets candidate and stable
// classes to unknown, candidate start time to zero, registers to defaults.
// ----------------------------------------------------------------------------
module orientation_classify_debounce (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        timestamp_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         raw_side,
	output logic [2:0]         stable_side,
	output logic               screen_down,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import ocd_pkg::*;

	cfg_t  cfg_q;
	logic  q_push, q_pop, q_full, q_empty;
	item_t q_item, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_axis_thr <= RST_SIDE_AXIS_THR;
			cfg_q.side_cross    <= RST_SIDE_CROSS;
			cfg_q.flat_axis_thr <= RST_FLAT_AXIS_THR;
			cfg_q.flat_cross    <= RST_FLAT_CROSS;
			cfg_q.settle_ms     <= RST_SETTLE_MS;
			cfg_q.face_down     <= RST_FACE_DOWN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SIDE_AXIS_THR: cfg_q.side_axis_thr <= cfg_data[14:0];
				REG_SIDE_CROSS:    cfg_q.side_cross    <= cfg_data[14:0];
				REG_FLAT_AXIS_THR: cfg_q.flat_axis_thr <= cfg_data[14:0];
				REG_FLAT_CROSS:    cfg_q.flat_cross    <= cfg_data[14:0];
				REG_SETTLE_MS:     cfg_q.settle_ms     <= cfg_data;
				REG_FACE_DOWN:     cfg_q.face_down     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	ocd_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.timestamp_ms (timestamp_ms),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	ocd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	ocd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.settle_ms   (cfg_q.settle_ms),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.raw_side    (raw_side),
		.stable_side (stable_side),
		.screen_down (screen_down)
	);

endmodule
